### src/parl_pkg.sv
// Package for the per-address rate limiter: table geometry, codes, entry record,
// command and status structs between controller and datapath, and the hash step.
// No dependencies.
`default_nettype none
package parl_pkg;

    // The table size must be a power of two.
    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int SCAN_W        = IDX_W + 1;
    localparam int CLEARED_W     = 11;
    localparam int COUNT_W       = 17;
    localparam int CFG_W         = 16;
    localparam logic [31:0] HASH_SEED = 32'd5381;

    localparam logic [CFG_W-1:0] LIMIT_RESET   = 16'd100;
    localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd10;

    typedef logic [IDX_W-1:0] idx_t;

    typedef enum logic [1:0] {
        REQ_CHECK  = 2'd0,
        REQ_SWEEP  = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_UNUSED = 2'd3
    } req_type_t;

    typedef enum logic {
        CFG_REQUEST_LIMIT = 1'b0,
        CFG_IDLE_TIMEOUT  = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_INIT_SCAN,
        ST_IDLE,
        ST_DISPATCH,
        ST_HASH_HI,
        ST_HASH_LO,
        ST_PROBE_RD,
        ST_PROBE_EV,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               used;
        logic [63:0]        addr_hi;
        logic [63:0]        addr_lo;
        logic [COUNT_W-1:0] count;
        logic [31:0]        win_sec;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic hash_hi;
        logic hash_lo;
        logic probe_rd;
        logic probe_ev;
        logic scan_start;
        logic scan_clear;
        logic scan;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       has_address;
        logic       probe_done;
        logic       scan_done;
    } status_t;

    // Eight DJB2 steps, one per byte, most significant byte first, kept modulo
    // the table size.
    function automatic idx_t djb_step8(idx_t h_in, logic [63:0] word);
        idx_t h;
        h = h_in;
        for (int k = 0; k < 8; k++)
        begin
            h = (h << 5) + h + IDX_W'(word[63 - 8 * k -: 8]);
        end
        return h;
    endfunction

endpackage
`default_nettype wire

### src/parl_req_if.sv
// Request channel of the rate limiter: valid, ready and the request item.
// No dependencies.
`default_nettype none
interface parl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] now_seconds;
    logic        has_address;
    logic [63:0] address_high;
    logic [63:0] address_low;

    modport source (output valid, req_type, now_seconds, has_address, address_high,
                    address_low, input ready);
    modport sink (input valid, req_type, now_seconds, has_address, address_high,
                  address_low, output ready);
endinterface
`default_nettype wire

### src/parl_rsp_if.sv
// Result channel of the rate limiter: valid, ready and the result item.
// No dependencies.
`default_nettype none
interface parl_rsp_if;
    logic        valid;
    logic        ready;
    logic        allowed;
    logic        first_over_limit;
    logic        new_entry;
    logic        table_full;
    logic [10:0] cleared_count;

    modport source (output valid, allowed, first_over_limit, new_entry, table_full,
                    cleared_count, input ready);
    modport sink (input valid, allowed, first_over_limit, new_entry, table_full,
                  cleared_count, output ready);
endinterface
`default_nettype wire

### src/parl_ctrl.sv
// Controller state machine of the rate limiter: sequences hashing, probing and
// table scans, and owns the handshakes. Depends on parl_pkg.
`default_nettype none
module parl_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    output logic                  rsp_valid,
    input  wire logic             rsp_ready,
    input  wire parl_pkg::status_t st,
    output parl_pkg::cmd_t        cmd
);

    parl_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= parl_pkg::ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            parl_pkg::ST_INIT:      state_next = parl_pkg::ST_INIT_SCAN;
            parl_pkg::ST_INIT_SCAN:
                if (st.scan_done) state_next = parl_pkg::ST_IDLE;
            parl_pkg::ST_IDLE:
                if (req_valid) state_next = parl_pkg::ST_DISPATCH;
            parl_pkg::ST_DISPATCH:
            begin
                case (st.req_type) inside
                    parl_pkg::REQ_CHECK:
                        state_next = st.has_address ? parl_pkg::ST_HASH_HI
                                                    : parl_pkg::ST_DONE;
                    parl_pkg::REQ_SWEEP, parl_pkg::REQ_CLEAR:
                        state_next = parl_pkg::ST_SCAN;
                    default: state_next = parl_pkg::ST_DONE;
                endcase
            end
            parl_pkg::ST_HASH_HI:   state_next = parl_pkg::ST_HASH_LO;
            parl_pkg::ST_HASH_LO:   state_next = parl_pkg::ST_PROBE_RD;
            parl_pkg::ST_PROBE_RD:  state_next = parl_pkg::ST_PROBE_EV;
            parl_pkg::ST_PROBE_EV:
                state_next = st.probe_done ? parl_pkg::ST_DONE : parl_pkg::ST_PROBE_RD;
            parl_pkg::ST_SCAN:
                if (st.scan_done) state_next = parl_pkg::ST_DONE;
            parl_pkg::ST_DONE:
                if (!out_valid_reg || rsp_ready) state_next = parl_pkg::ST_IDLE;
            default: state_next = parl_pkg::ST_INIT;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        req_ready      = 1'b0;
        out_valid_next = out_valid_reg && !rsp_ready;
        unique case (state_reg)
            parl_pkg::ST_INIT:
            begin
                cmd.scan_start = 1'b1;
                cmd.scan_clear = 1'b1;
            end
            parl_pkg::ST_INIT_SCAN: cmd.scan = 1'b1;
            parl_pkg::ST_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            parl_pkg::ST_DISPATCH:
            begin
                cmd.scan_start = (st.req_type == parl_pkg::REQ_SWEEP) ||
                                 (st.req_type == parl_pkg::REQ_CLEAR);
                cmd.scan_clear = (st.req_type == parl_pkg::REQ_CLEAR);
            end
            parl_pkg::ST_HASH_HI:  cmd.hash_hi  = 1'b1;
            parl_pkg::ST_HASH_LO:  cmd.hash_lo  = 1'b1;
            parl_pkg::ST_PROBE_RD: cmd.probe_rd = 1'b1;
            parl_pkg::ST_PROBE_EV: cmd.probe_ev = 1'b1;
            parl_pkg::ST_SCAN:     cmd.scan     = 1'b1;
            parl_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

    assign rsp_valid = out_valid_reg;

endmodule
`default_nettype wire

### src/parl_datapath.sv
// Datapath of the rate limiter: configuration registers, hash, table memory,
// probe and scan evaluation, result registers. Depends on parl_pkg.
`default_nettype none
module parl_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire parl_pkg::cmd_t                cmd,
    output parl_pkg::status_t                  st,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [parl_pkg::CFG_W-1:0]    cfg_data,
    input  wire logic [1:0]                    in_req_type,
    input  wire logic [31:0]                   in_now_seconds,
    input  wire logic                          in_has_address,
    input  wire logic [63:0]                   in_address_high,
    input  wire logic [63:0]                   in_address_low,
    output logic                               out_allowed,
    output logic                               out_first_over_limit,
    output logic                               out_new_entry,
    output logic                               out_table_full,
    output logic [parl_pkg::CLEARED_W-1:0]     out_cleared_count
);

    localparam logic [parl_pkg::SCAN_W-1:0] SCAN_END = parl_pkg::SCAN_W'(parl_pkg::TABLE_ENTRIES);
    localparam parl_pkg::idx_t LAST_PROBE = parl_pkg::IDX_W'(parl_pkg::TABLE_ENTRIES - 1);

    parl_pkg::entry_t mem [parl_pkg::TABLE_ENTRIES];
    parl_pkg::entry_t rd_data_reg, wr_data;
    parl_pkg::idx_t   rd_addr, wr_addr;
    logic             rd_en, wr_en;

    logic [parl_pkg::CFG_W-1:0] limit_reg, timeout_reg;
    logic [1:0]                 type_reg;
    logic                       has_reg;
    logic [31:0]                now_reg;
    logic [63:0]                hi_reg, lo_reg;
    parl_pkg::idx_t             hash_reg, idx_reg, probe_cnt_reg;

    logic [parl_pkg::SCAN_W-1:0] scan_addr_reg;
    logic                        scan_pipe_reg, scan_clear_reg;
    parl_pkg::idx_t              scan_idx_reg;
    logic [parl_pkg::CLEARED_W-1:0] freed_reg;

    logic res_allowed_reg, res_first_reg, res_new_reg, res_full_reg;

    logic free_slot, match, last_probe, expire;
    logic [parl_pkg::COUNT_W-1:0] limit_ext;
    logic [31:0] idle_age;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign free_slot  = !rd_data_reg.used;
    assign match      = rd_data_reg.used && (rd_data_reg.addr_hi == hi_reg) &&
                        (rd_data_reg.addr_lo == lo_reg);
    assign last_probe = (probe_cnt_reg == LAST_PROBE);
    assign limit_ext  = parl_pkg::COUNT_W'(limit_reg);
    assign idle_age   = now_reg - rd_data_reg.win_sec;
    assign expire     = rd_data_reg.used && (now_reg >= rd_data_reg.win_sec) &&
                        (idle_age > 32'(timeout_reg));

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = idx_reg;
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = rd_data_reg;
        if (cmd.probe_rd)
        begin
            rd_en = 1'b1;
        end
        if (cmd.scan && (scan_addr_reg < SCAN_END))
        begin
            rd_en   = 1'b1;
            rd_addr = scan_addr_reg[parl_pkg::IDX_W-1:0];
        end
        if (cmd.scan && scan_pipe_reg && (scan_clear_reg || expire))
        begin
            wr_en   = 1'b1;
            wr_addr = scan_idx_reg;
            wr_data = '0;
        end
        if (cmd.probe_ev)
        begin
            if (free_slot)
            begin
                wr_en   = 1'b1;
                wr_data = '{used: 1'b1, addr_hi: hi_reg, addr_lo: lo_reg,
                            count: parl_pkg::COUNT_W'(1), win_sec: now_reg};
            end
            else if (match)
            begin
                if (now_reg > rd_data_reg.win_sec)
                begin
                    wr_en           = 1'b1;
                    wr_data.count   = parl_pkg::COUNT_W'(1);
                    wr_data.win_sec = now_reg;
                end
                else if (rd_data_reg.count < limit_ext)
                begin
                    wr_en         = 1'b1;
                    wr_data.count = rd_data_reg.count + parl_pkg::COUNT_W'(1);
                end
                else if (rd_data_reg.count == limit_ext)
                begin
                    wr_en         = 1'b1;
                    wr_data.count = limit_ext + parl_pkg::COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= parl_pkg::LIMIT_RESET;
            timeout_reg   <= parl_pkg::TIMEOUT_RESET;
            scan_addr_reg <= '0;
            scan_pipe_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    parl_pkg::CFG_REQUEST_LIMIT: limit_reg   <= cfg_data;
                    parl_pkg::CFG_IDLE_TIMEOUT:  timeout_reg <= cfg_data;
                    default:                     limit_reg   <= limit_reg;
                endcase
            end
            if (cmd.scan_start)
            begin
                scan_addr_reg <= '0;
                scan_pipe_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                scan_pipe_reg <= (scan_addr_reg < SCAN_END);
                if (scan_addr_reg < SCAN_END)
                begin
                    scan_addr_reg <= scan_addr_reg + parl_pkg::SCAN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            type_reg        <= in_req_type;
            now_reg         <= in_now_seconds;
            has_reg         <= in_has_address;
            hi_reg          <= in_address_high;
            lo_reg          <= in_address_low;
            hash_reg        <= parl_pkg::IDX_W'(parl_pkg::HASH_SEED);
            freed_reg       <= '0;
            res_allowed_reg <= (in_req_type == parl_pkg::REQ_CHECK) && !in_has_address;
            res_first_reg   <= 1'b0;
            res_new_reg     <= 1'b0;
            res_full_reg    <= 1'b0;
        end
        if (cmd.hash_hi)
        begin
            hash_reg <= parl_pkg::djb_step8(hash_reg, hi_reg);
        end
        if (cmd.hash_lo)
        begin
            idx_reg       <= parl_pkg::djb_step8(hash_reg, lo_reg);
            probe_cnt_reg <= '0;
        end
        if (cmd.probe_ev)
        begin
            if (free_slot)
            begin
                res_allowed_reg <= 1'b1;
                res_new_reg     <= 1'b1;
            end
            else if (match)
            begin
                if ((now_reg > rd_data_reg.win_sec) || (rd_data_reg.count < limit_ext))
                begin
                    res_allowed_reg <= 1'b1;
                end
                else if (rd_data_reg.count == limit_ext)
                begin
                    res_first_reg <= 1'b1;
                end
            end
            else if (last_probe)
            begin
                res_allowed_reg <= 1'b1;
                res_full_reg    <= 1'b1;
            end
            else
            begin
                idx_reg       <= idx_reg + parl_pkg::IDX_W'(1);
                probe_cnt_reg <= probe_cnt_reg + parl_pkg::IDX_W'(1);
            end
        end
        if (cmd.scan_start)
        begin
            scan_clear_reg <= cmd.scan_clear;
        end
        if (cmd.scan)
        begin
            scan_idx_reg <= scan_addr_reg[parl_pkg::IDX_W-1:0];
            if (scan_pipe_reg && !scan_clear_reg && expire && (freed_reg != '1))
            begin
                freed_reg <= freed_reg + parl_pkg::CLEARED_W'(1);
            end
        end
        if (cmd.out_load)
        begin
            out_allowed          <= res_allowed_reg;
            out_first_over_limit <= res_first_reg;
            out_new_entry        <= res_new_reg;
            out_table_full       <= res_full_reg;
            out_cleared_count    <= freed_reg;
        end
    end

    assign st.req_type    = type_reg;
    assign st.has_address = has_reg;
    assign st.probe_done  = free_slot || match || last_probe;
    assign st.scan_done   = (scan_addr_reg == SCAN_END) && !scan_pipe_reg;

endmodule
`default_nettype wire

### src/per_address_rate_limiter.sv
// Per-address fixed-window rate limiter with a linear-probing client table; depends on
// parl_pkg, parl_req_if, parl_rsp_if, parl_ctrl and parl_datapath.
// One item at a time: ready rises again only after the result of the last item is loaded.
// After reset ready stays low while a clearing pass empties the table.
`default_nettype none
module per_address_rate_limiter (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    parl_req_if.sink                        req,
    parl_rsp_if.source                      rsp,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_index,
    input  wire logic [parl_pkg::CFG_W-1:0] cfg_data
);

    parl_pkg::cmd_t    cmd;
    parl_pkg::status_t st;

    parl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .st        (st),
        .cmd       (cmd)
    );

    parl_datapath u_datapath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .st                   (st),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .in_req_type          (req.req_type),
        .in_now_seconds       (req.now_seconds),
        .in_has_address       (req.has_address),
        .in_address_high      (req.address_high),
        .in_address_low       (req.address_low),
        .out_allowed          (rsp.allowed),
        .out_first_over_limit (rsp.first_over_limit),
        .out_new_entry        (rsp.new_entry),
        .out_table_full       (rsp.table_full),
        .out_cleared_count    (rsp.cleared_count)
    );

endmodule
`default_nettype wire

### src/parl_checker.sv
// Port checker for the rate limiter and its bind to the top level.
// Depends on per_address_rate_limiter.
`default_nettype none
module parl_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire logic allowed,
    input wire logic first_over_limit,
    input wire logic new_entry,
    input wire logic table_full
);

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("Result item dropped before it was taken.");

    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
    else $error("Second item accepted while the first is still in work.");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && first_over_limit |-> !allowed && !new_entry && !table_full)
    else $error("Over-limit flag on an item that was not denied.");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (new_entry || table_full) |-> allowed && !(new_entry && table_full))
    else $error("Inconsistent new-entry or table-full result.");

endmodule

bind per_address_rate_limiter parl_checker u_parl_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .allowed          (rsp.allowed),
    .first_over_limit (rsp.first_over_limit),
    .new_entry        (rsp.new_entry),
    .table_full       (rsp.table_full)
);
`default_nettype wire

### dv/tb_per_address_rate_limiter.sv
// Testbench for the per-address rate limiter: directed and random check, sweep and clear items
// against a behavioural table model. Depends on parl_pkg, parl_req_if, parl_rsp_if and the block.
`timescale 1ns / 100ps
module tb_per_address_rate_limiter;

    typedef struct packed {
        logic        allowed;
        logic        first_over_limit;
        logic        new_entry;
        logic        table_full;
        logic [10:0] cleared_count;
    } verdict_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    parl_pkg::cfg_index_t cfg_index;
    logic [parl_pkg::CFG_W-1:0] cfg_data;
    bit failed;
    int unsigned cycles;

    parl_req_if req();
    parl_rsp_if rsp();

    per_address_rate_limiter uut (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    logic [15:0] lim_m;
    logic [15:0] tmo_m;
    bit          used_m [parl_pkg::TABLE_ENTRIES];
    logic [63:0] hi_m [parl_pkg::TABLE_ENTRIES];
    logic [63:0] lo_m [parl_pkg::TABLE_ENTRIES];
    logic [16:0] cnt_m [parl_pkg::TABLE_ENTRIES];
    logic [31:0] win_m [parl_pkg::TABLE_ENTRIES];
    verdict_t    pending_verdicts[$];
    logic [63:0] known_hi[$];
    logic [63:0] known_lo[$];

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) cycles <= cycles + 1;

    initial
    begin
        wait (cycles > 2000000);
        $display("[per_address_rate_limiter] ERROR");
        $finish;
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [9:0] djb_index(logic [63:0] hi, logic [63:0] lo);
        logic [63:0] h;
        logic [127:0] a;
        h = 64'd5381;
        a = {hi, lo};
        for (int k = 0; k < 16; k++)
        begin
            h = (h << 5) + h + 64'(a[127 - 8 * k -: 8]);
        end
        return h[9:0];
    endfunction

    function automatic verdict_t predict_verdict(parl_pkg::req_type_t t, logic [31:0] now,
                                                 logic has, logic [63:0] hi, logic [63:0] lo);
        verdict_t v;
        logic [9:0] idx;
        logic [10:0] freed;
        bit done;
        v = '0;
        done = 1'b0;
        if (t == parl_pkg::REQ_CHECK)
        begin
            if (!has)
            begin
                v.allowed = 1'b1;
            end
            else
            begin
                idx = djb_index(hi, lo);
                for (int i = 0; i < parl_pkg::TABLE_ENTRIES && !done; i++)
                begin
                    if (!used_m[idx])
                    begin
                        used_m[idx] = 1'b1;
                        hi_m[idx] = hi;
                        lo_m[idx] = lo;
                        cnt_m[idx] = 17'd1;
                        win_m[idx] = now;
                        v.allowed = 1'b1;
                        v.new_entry = 1'b1;
                        done = 1'b1;
                    end
                    else if (hi_m[idx] == hi && lo_m[idx] == lo)
                    begin
                        if (now > win_m[idx])
                        begin
                            cnt_m[idx] = 17'd1;
                            win_m[idx] = now;
                            v.allowed = 1'b1;
                        end
                        else if (cnt_m[idx] < {1'b0, lim_m})
                        begin
                            cnt_m[idx] = cnt_m[idx] + 17'd1;
                            v.allowed = 1'b1;
                        end
                        else if (cnt_m[idx] == {1'b0, lim_m})
                        begin
                            v.first_over_limit = 1'b1;
                            cnt_m[idx] = {1'b0, lim_m} + 17'd1;
                        end
                        done = 1'b1;
                    end
                    idx = idx + 10'd1;
                end
                if (!done)
                begin
                    v.allowed = 1'b1;
                    v.table_full = 1'b1;
                end
            end
        end
        else if (t == parl_pkg::REQ_SWEEP)
        begin
            freed = '0;
            for (int i = 0; i < parl_pkg::TABLE_ENTRIES; i++)
            begin
                if (used_m[i] && now >= win_m[i] && (now - win_m[i]) > {16'd0, tmo_m})
                begin
                    used_m[i] = 1'b0;
                    if (freed != 11'h7FF) freed = freed + 11'd1;
                end
            end
            v.cleared_count = freed;
        end
        else if (t == parl_pkg::REQ_CLEAR)
        begin
            for (int i = 0; i < parl_pkg::TABLE_ENTRIES; i++) used_m[i] = 1'b0;
        end
        return v;
    endfunction

    task automatic send_request(parl_pkg::req_type_t t, logic [31:0] now, logic has,
                                logic [63:0] hi, logic [63:0] lo);
        @(posedge clk);
        repeat (gap_len()) @(posedge clk);
        pending_verdicts.push_back(predict_verdict(t, now, has, hi, lo));
        req.valid <= 1;
        req.req_type <= t;
        req.now_seconds <= now;
        req.has_address <= has;
        req.address_high <= hi;
        req.address_low <= lo;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        req.valid <= 0;
    endtask

    task automatic drain();
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_register(parl_pkg::cfg_index_t i, logic [15:0] d);
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= i;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 0;
        if (i == parl_pkg::CFG_REQUEST_LIMIT) lim_m = d;
        else tmo_m = d;
    endtask

    always @(posedge clk)
    begin
        verdict_t e;
        if (rsp.valid && rsp.ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("unexpected result item");
                failed = 1;
            end
            else
            begin
                e = pending_verdicts.pop_front();
                if (rsp.allowed !== e.allowed)
                begin
                    $error("allowed exp %0d got %0d", e.allowed, rsp.allowed);
                    failed = 1;
                end
                if (rsp.first_over_limit !== e.first_over_limit)
                begin
                    $error("first_over_limit exp %0d got %0d", e.first_over_limit,
                           rsp.first_over_limit);
                    failed = 1;
                end
                if (rsp.new_entry !== e.new_entry)
                begin
                    $error("new_entry exp %0d got %0d", e.new_entry, rsp.new_entry);
                    failed = 1;
                end
                if (rsp.table_full !== e.table_full)
                begin
                    $error("table_full exp %0d got %0d", e.table_full, rsp.table_full);
                    failed = 1;
                end
                if (rsp.cleared_count !== e.cleared_count)
                begin
                    $error("cleared_count exp %0d got %0d", e.cleared_count,
                           rsp.cleared_count);
                    failed = 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        rsp.ready <= ($urandom_range(0, 9) < 7) ? 1'b1 : ($urandom_range(0, 20) == 0);
    end

    task automatic test_directed();
        logic [63:0] a;
        a = 64'h0123_4567_89AB_CDEF;
        send_request(parl_pkg::REQ_CHECK, 32'd5, 1'b0, 64'd0, 64'd0);
        send_request(parl_pkg::REQ_CHECK, 32'd0, 1'b1, 64'd0, 64'd0);
        send_request(parl_pkg::REQ_CHECK, 32'hFFFF_FFFF, 1'b1, '1, '1);
        send_request(parl_pkg::REQ_CHECK, 32'd10, 1'b1, a, ~a);
        for (int i = 0; i < 4; i++) send_request(parl_pkg::REQ_CHECK, 32'd10, 1'b1, a, ~a);
        send_request(parl_pkg::REQ_CHECK, 32'd9, 1'b1, a, ~a);
        send_request(parl_pkg::REQ_CHECK, 32'd11, 1'b1, a, ~a);
        send_request(parl_pkg::REQ_UNUSED, 32'd99, 1'b1, a, a);
        send_request(parl_pkg::REQ_SWEEP, 32'd3, 1'b0, 64'd0, 64'd0);
        send_request(parl_pkg::REQ_SWEEP, 32'd100, 1'b0, 64'd0, 64'd0);
        send_request(parl_pkg::REQ_SWEEP, 32'hFFFF_FFFF, 1'b0, 64'd0, 64'd0);
        send_request(parl_pkg::REQ_CLEAR, 32'd0, 1'b0, 64'd0, 64'd0);
        drain();
    endtask

    task automatic test_limits();
        write_register(parl_pkg::CFG_REQUEST_LIMIT, 16'd0);
        write_register(parl_pkg::CFG_IDLE_TIMEOUT, 16'd0);
        for (int i = 0; i < 4; i++)
            send_request(parl_pkg::REQ_CHECK, 32'd20, 1'b1, 64'd7, 64'd8);
        send_request(parl_pkg::REQ_SWEEP, 32'd20, 1'b0, 64'd0, 64'd0);
        send_request(parl_pkg::REQ_SWEEP, 32'd21, 1'b0, 64'd0, 64'd0);
        drain();
        write_register(parl_pkg::CFG_REQUEST_LIMIT, 16'd2);
        write_register(parl_pkg::CFG_IDLE_TIMEOUT, 16'hFFFF);
        for (int i = 0; i < 6; i++)
            send_request(parl_pkg::REQ_CHECK, 32'd30, 1'b1, 64'd1, 64'd2);
        send_request(parl_pkg::REQ_SWEEP, 32'd70000, 1'b0, 64'd0, 64'd0);
        drain();
    endtask

    task automatic test_random(int n);
        parl_pkg::req_type_t t;
        logic [63:0] hi, lo;
        logic [31:0] now;
        int r;
        int k;
        now = 32'd1000;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 3) == 0) now = now + $urandom_range(0, 3);
            if (r < 3) now = $urandom;
            if (r < 80)
            begin
                if (known_hi.size() != 0 && $urandom_range(0, 2) != 0)
                begin
                    k = $urandom_range(0, known_hi.size() - 1);
                    hi = known_hi[k];
                    lo = known_lo[k];
                end
                else
                begin
                    hi = {$urandom, $urandom};
                    lo = {$urandom, $urandom};
                    known_hi.push_back(hi);
                    known_lo.push_back(lo);
                end
                send_request(parl_pkg::REQ_CHECK, now, $urandom_range(0, 15) != 0, hi, lo);
            end
            else if (r < 92)
            begin
                send_request(parl_pkg::REQ_SWEEP, now + $urandom_range(0, 20), 1'b0,
                             64'd0, 64'd0);
            end
            else
            begin
                t = (r < 96) ? parl_pkg::REQ_CLEAR : parl_pkg::REQ_UNUSED;
                send_request(t, $urandom, 1'($urandom_range(0, 1)),
                             {$urandom, $urandom}, {$urandom, $urandom});
            end
        end
        drain();
    endtask

    task automatic test_dense_table();
        logic [63:0] hi, lo;
        logic [63:0] chain_lo[$];
        hi = 64'h5A5A_0000_0000_0001;
        write_register(parl_pkg::CFG_REQUEST_LIMIT, 16'hFFFF);
        write_register(parl_pkg::CFG_IDLE_TIMEOUT, 16'd1);
        send_request(parl_pkg::REQ_CLEAR, 32'd0, 1'b0, 64'd0, 64'd0);
        for (int i = 0; i < 40; i++)
        begin
            lo = {$urandom, $urandom};
            while (djb_index(hi, lo) != 10'd1018) lo = {$urandom, $urandom};
            chain_lo.push_back(lo);
            send_request(parl_pkg::REQ_CHECK, 32'd50, 1'b1, hi, lo);
        end
        for (int i = 0; i < 10; i++)
        begin
            send_request(parl_pkg::REQ_CHECK, 32'd50, 1'b1, hi,
                         chain_lo[$urandom_range(0, 39)]);
        end
        send_request(parl_pkg::REQ_SWEEP, 32'd60, 1'b0, 64'd0, 64'd0);
        send_request(parl_pkg::REQ_CHECK, 32'd60, 1'b1, hi, chain_lo[39]);
        drain();
    endtask

    initial
    begin
        rst_n = 0;
        cycles = 0;
        failed = 0;
        cfg_we = 0;
        cfg_index = parl_pkg::CFG_REQUEST_LIMIT;
        cfg_data = '0;
        req.valid = 0;
        req.req_type = parl_pkg::REQ_CHECK;
        req.now_seconds = '0;
        req.has_address = 0;
        req.address_high = '0;
        req.address_low = '0;
        rsp.ready = 0;
        lim_m = parl_pkg::LIMIT_RESET;
        tmo_m = parl_pkg::TIMEOUT_RESET;
        for (int i = 0; i < parl_pkg::TABLE_ENTRIES; i++) used_m[i] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        test_limits();
        write_register(parl_pkg::CFG_REQUEST_LIMIT, 16'd3);
        write_register(parl_pkg::CFG_IDLE_TIMEOUT, 16'd4);
        test_random(200);
        write_register(parl_pkg::CFG_REQUEST_LIMIT, parl_pkg::LIMIT_RESET);
        write_register(parl_pkg::CFG_IDLE_TIMEOUT, parl_pkg::TIMEOUT_RESET);
        test_random(120);
        test_dense_table();
        if (!failed)
            $display("[per_address_rate_limiter] OK");
        else
            $display("[per_address_rate_limiter] ERROR");
        $finish;
    end
endmodule

### per_address_rate_limiter.f
src/parl_pkg.sv
src/parl_req_if.sv
src/parl_rsp_if.sv
src/parl_ctrl.sv
src/parl_datapath.sv
src/per_address_rate_limiter.sv
src/parl_checker.sv
dv/tb_per_address_rate_limiter.sv
